/* rtl/core/cob_pkg.sv */
package cob_pkg;

  // Field and register widths.
  localparam int REG_W  = 48;   // one configuration register
  localparam int COMP_W = 16;   // one Q8.8 component
  localparam int DIFF_W = 17;   // input minus origin
  localparam int PROD_W = 32;   // product of two components
  localparam int ADJ_W  = 33;   // one adjugate entry
  localparam int MUL_W  = 50;   // adjugate entry times a difference
  localparam int DPR_W  = 49;   // component times adjugate entry
  localparam int DSUM_W = 51;   // signed determinant
  localparam int DET_W  = 48;   // determinant magnitude
  localparam int LIM_W  = 64;   // overflow limit of the quotient
  localparam int NUM_W  = 52;   // signed numerator or direct result
  localparam int QUO_W  = 32;   // quotient bits, one per divider step
  localparam int OUT_W  = 32;   // Q16.16 result component
  localparam int FRAC_SH = 16;  // numerator is scaled by 2^16 before the divide

  localparam logic [REG_W-1:0] BASIS_I_RESET = 48'd256;
  localparam logic [REG_W-1:0] BASIS_J_RESET = 48'd16777216;
  localparam logic [REG_W-1:0] BASIS_K_RESET = 48'd1099511627776;
  localparam logic [REG_W-1:0] ORIGIN_RESET  = 48'd0;

  localparam logic [1:0] REG_BASIS_I = 2'd0;
  localparam logic [1:0] REG_BASIS_J = 2'd1;
  localparam logic [1:0] REG_BASIS_K = 2'd2;
  localparam logic [1:0] REG_ORIGIN  = 2'd3;

  // Cycles the derived basis data needs after a register changes.
  localparam logic [2:0] SETTLE_CYCLES = 3'd6;

  localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_POINT_FROM  = 2'd0,
    OP_POINT_TO    = 2'd1,
    OP_VECTOR_FROM = 2'd2,
    OP_VECTOR_TO   = 2'd3
  } cob_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BASIS = 2'd1,
    ST_SATURATED = 2'd2
  } cob_status_t;

  typedef logic [ADJ_W-1:0] cob_adj_t;

  // Everything derived from the basis registers alone.
  typedef struct packed {
    cob_adj_t [2:0][2:0] adj;
    logic [DET_W-1:0]    det_mag;
    logic [LIM_W-1:0]    ov_limit;
    logic                det_neg;
    logic                det_zero;
  } cob_basis_t;

  // One result component on its way through the divider.
  typedef struct packed {
    logic [DET_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic             neg;
    logic             ov;
    logic [OUT_W-1:0] to_val;
    logic             to_sat;
  } cob_lane_t;

  typedef struct packed {
    logic                from_global;
    cob_lane_t [2:0]     lane;
  } cob_item_t;

  function automatic logic signed [COMP_W-1:0] comp(input logic [REG_W-1:0] r,
                                                   input logic [1:0] idx);
    logic signed [COMP_W-1:0] c;
    case (idx)
      2'd0:    c = r[15:0];
      2'd1:    c = r[31:16];
      2'd2:    c = r[47:32];
      default: c = r[15:0];
    endcase
    return c;
  endfunction

  function automatic logic is_sat(input logic signed [NUM_W-1:0] v);
    return !((&v[NUM_W-1:OUT_W-1]) || !(|v[NUM_W-1:OUT_W-1]));
  endfunction

  function automatic logic [OUT_W-1:0] sat_val(input logic signed [NUM_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (is_sat(v)) begin
      r = v[NUM_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/change_of_basis_3d.sv */
// Throughput: one word per cycle while in_stall is low; the quotient pipeline has 32 steps.
// After reset and after every configuration write, in_stall stays high
// while the adjugate and determinant pipeline settles.
// Reset (rst, synchronous) restores the identity basis with a zero origin and
// empties the pipeline and the output skid register.
module change_of_basis_3d (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic signed [cob_pkg::COMP_W-1:0] in_x,
  input  logic signed [cob_pkg::COMP_W-1:0] in_y,
  input  logic signed [cob_pkg::COMP_W-1:0] in_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cob_pkg::OUT_W-1:0]  out_x,
  output logic signed [cob_pkg::OUT_W-1:0]  out_y,
  output logic signed [cob_pkg::OUT_W-1:0]  out_z,
  output logic [1:0]                        status,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [cob_pkg::REG_W-1:0]         cfg_data
);
  import cob_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0] basis_i, basis_j, basis_k, origin_point;
  logic [2:0]       settle;

  // The whole pipeline moves together; it halts only while the skid register
  // holds a word that the consumer has not taken yet.
  logic       adv;
  logic       accept;

  cob_basis_t basis_q;

  logic       div_valid [QUO_W+1];
  cob_item_t  div_item  [QUO_W+1];

  logic [OUT_W-1:0] rnd_val [3];
  logic             rnd_sat [3];
  logic [OUT_W-1:0] res_val [3];
  cob_status_t      res_status;

  logic             fin_valid;
  logic [OUT_W-1:0] fin_val [3];
  cob_status_t      fin_status;
  logic             skid_valid;
  logic [OUT_W-1:0] skid_val [3];
  cob_status_t      skid_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_i      <= BASIS_I_RESET;
      basis_j      <= BASIS_J_RESET;
      basis_k      <= BASIS_K_RESET;
      origin_point <= ORIGIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASIS_I: basis_i      <= cfg_data;
        REG_BASIS_J: basis_j      <= cfg_data;
        REG_BASIS_K: basis_k      <= cfg_data;
        REG_ORIGIN:  origin_point <= cfg_data;
        default:     basis_i      <= basis_i;
      endcase
    end
  end

  // Hold off new words until the derived basis data reflects the registers.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  assign adv      = !skid_valid;
  assign in_stall = skid_valid || (settle != 3'd0);
  assign accept   = in_valid && !in_stall;

  cob_basis u_basis (
    .clk     (clk),
    .basis_i (basis_i),
    .basis_j (basis_j),
    .basis_k (basis_k),
    .basis   (basis_q)
  );

  // Offset, matrix products and sums, then the magnitude and overflow
  // check that prepare the divide.
  cob_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .accept       (accept),
    .opcode       (opcode),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .basis_i      (basis_i),
    .basis_j      (basis_j),
    .basis_k      (basis_k),
    .origin_point (origin_point),
    .basis        (basis_q),
    .valid        (div_valid[0]),
    .item         (div_item[0])
  );

  // One quotient bit per stage for each of the three components.
  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    cob_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .det_mag   (basis_q.det_mag),
      .in_valid  (div_valid[s]),
      .in_item   (div_item[s]),
      .out_valid (div_valid[s+1]),
      .out_item  (div_item[s+1])
    );
  end

  // Round to nearest with ties away from zero, apply the sign, and clamp.
  // A quotient that is already known to overflow takes the clamped value.
  for (genvar n = 0; n < 3; n++) begin : g_round
    logic             rnd_up;
    logic [OUT_W:0]   mag;
    cob_lane_t        ln;

    assign ln     = div_item[QUO_W].lane[n];
    assign rnd_up = {ln.rem, 1'b0} >= {1'b0, basis_q.det_mag};
    assign mag    = ln.ov ? {1'b1, {OUT_W{1'b0}}} : {1'b0, ln.low} + (OUT_W+1)'(rnd_up);
    assign rnd_sat[n] = ln.neg ? (mag > (OUT_W+1)'(OUT_MIN)) : (mag > (OUT_W+1)'(OUT_MAX));
    assign rnd_val[n] = rnd_sat[n] ? (ln.neg ? OUT_MIN : OUT_MAX) :
                        (ln.neg ? -mag[OUT_W-1:0] : mag[OUT_W-1:0]);
  end

  always_comb begin
    res_status = ST_OK;
    for (int n = 0; n < 3; n++) begin
      if (div_item[QUO_W].from_global) begin
        res_val[n] = rnd_val[n];
        if (rnd_sat[n]) begin
          res_status = ST_SATURATED;
        end
      end else begin
        res_val[n] = div_item[QUO_W].lane[n].to_val;
        if (div_item[QUO_W].lane[n].to_sat) begin
          res_status = ST_SATURATED;
        end
      end
    end
    // A singular basis gives zeros for every operation.
    if (basis_q.det_zero) begin
      res_status = ST_NOT_BASIS;
      for (int n = 0; n < 3; n++) begin
        res_val[n] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= div_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_val    <= res_val;
      fin_status <= res_status;
    end
  end

  // The skid register catches the final word when the consumer stalls, so
  // the pipeline can take one more step and the input side sees a
  // registered stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (fin_valid && out_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && fin_valid && out_stall) begin
      skid_val    <= fin_val;
      skid_status <= fin_status;
    end
  end

  assign out_valid = skid_valid || fin_valid;
  assign out_x     = skid_valid ? skid_val[0] : fin_val[0];
  assign out_y     = skid_valid ? skid_val[1] : fin_val[1];
  assign out_z     = skid_valid ? skid_val[2] : fin_val[2];
  assign status    = skid_valid ? skid_status : fin_status;

`ifndef SYNTHESIS
  // No word may enter right after a register write; the derived data lags.
  a_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("word accepted while basis data settles");

  a_not_basis: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOT_BASIS) |-> (out_x == 0 && out_y == 0 && out_z == 0))
    else $error("singular basis with nonzero result");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SATURATED) |->
      (out_x == OUT_MAX || out_x == OUT_MIN || out_y == OUT_MAX || out_y == OUT_MIN ||
       out_z == OUT_MAX || out_z == OUT_MIN))
    else $error("saturated status without a clamped component");
`endif

endmodule

/* rtl/core/cob_basis.sv */
module cob_basis (
  input  logic                       clk,
  input  logic [cob_pkg::REG_W-1:0]  basis_i,
  input  logic [cob_pkg::REG_W-1:0]  basis_j,
  input  logic [cob_pkg::REG_W-1:0]  basis_k,
  output cob_pkg::cob_basis_t        basis
);
  import cob_pkg::*;

  logic signed [COMP_W-1:0] vecs [3][3];
  logic signed [PROD_W-1:0] pa [3][3];
  logic signed [PROD_W-1:0] pb [3][3];
  logic signed [ADJ_W-1:0]  adj [3][3];
  logic signed [DPR_W-1:0]  dp [3];
  logic signed [DSUM_W-1:0] det;
  logic [DET_W-1:0]         det_mag;
  logic                     det_neg;
  logic                     det_zero;
  logic [LIM_W-1:0]         ov_limit;

  // Rows of the adjugate are j x k, k x i and i x j.
  for (genvar m = 0; m < 3; m++) begin : g_unpack
    assign vecs[0][m] = comp(basis_i, 2'(m));
    assign vecs[1][m] = comp(basis_j, 2'(m));
    assign vecs[2][m] = comp(basis_k, 2'(m));
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        pa[r][c]  <= vecs[(r+1)%3][(c+1)%3] * vecs[(r+2)%3][(c+2)%3];
        pb[r][c]  <= vecs[(r+1)%3][(c+2)%3] * vecs[(r+2)%3][(c+1)%3];
        adj[r][c] <= ADJ_W'(pa[r][c]) - ADJ_W'(pb[r][c]);
      end
      assign basis.adj[r][c] = adj[r][c];
    end
  end

  for (genvar m = 0; m < 3; m++) begin : g_det
    always_ff @(posedge clk) begin
      dp[m] <= vecs[0][m] * adj[0][m];
    end
  end

  always_ff @(posedge clk) begin
    det      <= DSUM_W'(dp[0]) + DSUM_W'(dp[1]) + DSUM_W'(dp[2]);
    det_neg  <= det[DSUM_W-1];
    det_zero <= (det == '0);
    det_mag  <= DET_W'(det[DSUM_W-1] ? -det : det);
    ov_limit <= {1'b0, det_mag, 15'b0} + LIM_W'(det_mag);
  end

  assign basis.det_mag  = det_mag;
  assign basis.det_neg  = det_neg;
  assign basis.det_zero = det_zero;
  assign basis.ov_limit = ov_limit;

endmodule

/* rtl/core/cob_front.sv */
module cob_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              accept,
  input  logic [1:0]                        opcode,
  input  logic signed [cob_pkg::COMP_W-1:0] in_x,
  input  logic signed [cob_pkg::COMP_W-1:0] in_y,
  input  logic signed [cob_pkg::COMP_W-1:0] in_z,
  input  logic [cob_pkg::REG_W-1:0]         basis_i,
  input  logic [cob_pkg::REG_W-1:0]         basis_j,
  input  logic [cob_pkg::REG_W-1:0]         basis_k,
  input  logic [cob_pkg::REG_W-1:0]         origin_point,
  input  cob_pkg::cob_basis_t               basis,
  output logic                              valid,
  output cob_pkg::cob_item_t                item
);
  import cob_pkg::*;

  logic signed [COMP_W-1:0] pin [3];
  logic signed [COMP_W-1:0] org [3];
  logic signed [COMP_W-1:0] vecs [3][3];
  logic signed [ADJ_W-1:0]  amul [3][3];

  logic                     v1, v2, v3, v4;
  cob_op_t                  op1, op2;
  logic                     from3, from4;
  logic signed [DIFF_W-1:0] b1 [3];
  logic signed [MUL_W-1:0]  prod2 [3][3];
  logic signed [NUM_W-1:0]  num3 [3];
  logic [NUM_W-1:0]         mag4 [3];
  logic                     neg4 [3];
  logic [OUT_W-1:0]         tov4 [3];
  logic                     tos4 [3];

  assign pin[0] = in_x;
  assign pin[1] = in_y;
  assign pin[2] = in_z;

  for (genvar m = 0; m < 3; m++) begin : g_unpack
    assign org[m]     = comp(origin_point, 2'(m));
    assign vecs[0][m] = comp(basis_i, 2'(m));
    assign vecs[1][m] = comp(basis_j, 2'(m));
    assign vecs[2][m] = comp(basis_k, 2'(m));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= cob_op_t'(opcode);
      op2 <= op1;
      from3 <= (op2 == OP_POINT_FROM) || (op2 == OP_VECTOR_FROM);
      from4 <= from3;
      item.from_global <= from4;
    end
  end

  for (genvar n = 0; n < 3; n++) begin : g_lane
    // From global uses the adjugate rows; to global uses the basis columns.
    for (genvar m = 0; m < 3; m++) begin : g_term
      assign amul[n][m] = ((op1 == OP_POINT_FROM) || (op1 == OP_VECTOR_FROM)) ?
                          $signed(basis.adj[n][m]) : ADJ_W'(vecs[m][n]);
      always_ff @(posedge clk) begin
        if (adv) begin
          prod2[n][m] <= amul[n][m] * b1[m];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        b1[n] <= (cob_op_t'(opcode) == OP_POINT_FROM) ?
                 DIFF_W'(pin[n]) - DIFF_W'(org[n]) : DIFF_W'(pin[n]);
        num3[n] <= NUM_W'(prod2[n][0]) + NUM_W'(prod2[n][1]) + NUM_W'(prod2[n][2]) +
                   ((op2 == OP_POINT_TO) ? (NUM_W'(org[n]) <<< 8) : NUM_W'(0));
        mag4[n] <= num3[n][NUM_W-1] ? NUM_W'(-num3[n]) : NUM_W'(num3[n]);
        neg4[n] <= num3[n][NUM_W-1] ^ basis.det_neg;
        tov4[n] <= sat_val(num3[n]);
        tos4[n] <= is_sat(num3[n]);
        item.lane[n].rem    <= DET_W'(mag4[n][NUM_W-1:FRAC_SH]);
        item.lane[n].low    <= {mag4[n][FRAC_SH-1:0], {FRAC_SH{1'b0}}};
        item.lane[n].neg    <= neg4[n];
        item.lane[n].ov     <= LIM_W'(mag4[n]) >= basis.ov_limit;
        item.lane[n].to_val <= tov4[n];
        item.lane[n].to_sat <= tos4[n];
      end
    end
  end

endmodule

/* rtl/core/cob_div_step.sv */
module cob_div_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic [cob_pkg::DET_W-1:0]  det_mag,
  input  logic                       in_valid,
  input  cob_pkg::cob_item_t         in_item,
  output logic                       out_valid,
  output cob_pkg::cob_item_t         out_item
);
  import cob_pkg::*;

  logic [DET_W:0]   t    [3];
  logic [DET_W:0]   diff [3];
  logic             ge   [3];
  cob_item_t        nxt;

  // One restoring step per lane: bring in the next dividend bit, then
  // subtract the divisor if it fits.
  always_comb begin
    nxt = in_item;
    for (int n = 0; n < 3; n++) begin
      t[n]    = {in_item.lane[n].rem, in_item.lane[n].low[QUO_W-1]};
      diff[n] = t[n] - {1'b0, det_mag};
      ge[n]   = t[n] >= {1'b0, det_mag};
      nxt.lane[n].rem = ge[n] ? diff[n][DET_W-1:0] : t[n][DET_W-1:0];
      nxt.lane[n].low = {in_item.lane[n].low[QUO_W-2:0], ge[n]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= nxt;
    end
  end

endmodule

/* dv/tb_change_of_basis_3d.sv */
`timescale 1ns / 100ps

module tb_change_of_basis_3d;
  import cob_pkg::*;

  // One result word as the block presents it on the output side.
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    cob_status_t             st;
  } coord_word_t;

  // One line of the directed plan. A line is either a register write or an
  // input word. When typed is set, the expected result is written into the
  // line itself; otherwise the transform predictor supplies it.
  typedef struct {
    bit                 is_cfg;
    logic [1:0]         idx;
    logic [REG_W-1:0]   data;
    cob_op_t            op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    bit                 typed;
    int                 ex;
    int                 ey;
    int                 ez;
    cob_status_t        st;
  } plan_line_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               opcode;
  logic signed [COMP_W-1:0] in_x;
  logic signed [COMP_W-1:0] in_y;
  logic signed [COMP_W-1:0] in_z;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [OUT_W-1:0]  out_x;
  logic signed [OUT_W-1:0]  out_y;
  logic signed [OUT_W-1:0]  out_z;
  logic [1:0]               status;
  logic                     cfg_write;
  logic [1:0]               cfg_index;
  logic [REG_W-1:0]         cfg_data;

  change_of_basis_3d uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the four configuration registers, in register index order.
  logic [REG_W-1:0] basis_regs [4];

  // Results still owed by the block, oldest first.
  coord_word_t pending_words [$];

  int  mismatches = 0;
  bit  idle_on = 1;      // when clear, neither side inserts gaps or stalls
  bit  long_hold = 0;    // asks the receiver for one long stall
  int  hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous fixed limit; a correct run needs a small fraction of it.
  initial begin
    #4000000;
    $display("change_of_basis_3d test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  function automatic longint comp_of(input logic [REG_W-1:0] r, input int n);
    return longint'($signed(r[16*n +: 16]));
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Rounds n * 2^16 / d to nearest, ties away from zero. A quotient whose
  // integer part exceeds 2^15 is pinned at 2^32 so that it saturates later.
  function automatic longint scaled_quotient(input longint n, input longint d);
    bit                neg;
    longint unsigned   un, ud, q0, r, fr, f, rm, mag;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? longint'(-n) : n;
    ud = (d < 0) ? longint'(-d) : d;
    q0 = un / ud;
    r  = un % ud;
    if (q0 > 64'd32768) begin
      mag = 64'h1_0000_0000;
    end else begin
      fr  = r << 16;
      f   = fr / ud;
      rm  = fr % ud;
      mag = (q0 << 16) + f + ((2 * rm >= ud) ? 64'd1 : 64'd0);
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Predicts the result word for one input word under the current registers.
  function automatic coord_word_t transform(input cob_op_t op,
                                            input logic signed [15:0] px,
                                            input logic signed [15:0] py,
                                            input logic signed [15:0] pz);
    longint      vi[3], vj[3], vk[3], org[3], p[3], acc[3];
    longint      a0[3], a1[3], a2[3];
    longint      det;
    bit          sat;
    coord_word_t w;
    for (int n = 0; n < 3; n++) begin
      vi[n]  = comp_of(basis_regs[REG_BASIS_I], n);
      vj[n]  = comp_of(basis_regs[REG_BASIS_J], n);
      vk[n]  = comp_of(basis_regs[REG_BASIS_K], n);
      org[n] = comp_of(basis_regs[REG_ORIGIN], n);
    end
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    cross3(vj, vk, a0);
    cross3(vk, vi, a1);
    cross3(vi, vj, a2);
    det = vi[0] * a0[0] + vi[1] * a0[1] + vi[2] * a0[2];
    if (det == 0) begin
      w = '{x: 0, y: 0, z: 0, st: ST_NOT_BASIS};
      return w;
    end
    if (op == OP_POINT_FROM || op == OP_VECTOR_FROM) begin
      if (op == OP_POINT_FROM) begin
        for (int n = 0; n < 3; n++) p[n] -= org[n];
      end
      acc[0] = scaled_quotient(a0[0] * p[0] + a0[1] * p[1] + a0[2] * p[2], det);
      acc[1] = scaled_quotient(a1[0] * p[0] + a1[1] * p[1] + a1[2] * p[2], det);
      acc[2] = scaled_quotient(a2[0] * p[0] + a2[1] * p[1] + a2[2] * p[2], det);
    end else begin
      for (int n = 0; n < 3; n++) begin
        acc[n] = vi[n] * p[0] + vj[n] * p[1] + vk[n] * p[2];
        if (op == OP_POINT_TO) acc[n] += org[n] * 256;
      end
    end
    // Clamp each component into the signed 32-bit range.
    sat = 0;
    for (int n = 0; n < 3; n++) begin
      if (acc[n] > 64'sd2147483647) begin
        acc[n] = 64'sd2147483647;
        sat = 1;
      end
      if (acc[n] < -64'sd2147483648) begin
        acc[n] = -64'sd2147483648;
        sat = 1;
      end
    end
    w.x  = acc[0][31:0];
    w.y  = acc[1][31:0];
    w.z  = acc[2][31:0];
    w.st = sat ? ST_SATURATED : ST_OK;
    return w;
  endfunction

  // Offers one word after a random gap (none when idle_on is clear) and holds it
  // until the block takes it. Entered and left at a falling edge.
  task automatic send_word(input cob_op_t op, input logic signed [15:0] px,
                           input logic signed [15:0] py, input logic signed [15:0] pz,
                           input coord_word_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    opcode   = op;
    in_x     = px;
    in_y     = py;
    in_z     = pz;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(want);
    @(negedge clk);
  endtask

  // Registers change only with the block drained. Every word yields a
  // result, so an empty queue means the pipeline is empty; the extra wait
  // covers the pipeline latency anyway.
  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    basis_regs[idx] = val;
  endtask

  function automatic logic [15:0] rand_comp();
    logic [15:0] c;
    case ($urandom_range(0, 5))
      0: c = 16'($urandom);
      1, 2: c = 16'($signed($urandom_range(0, 1200)) - 600);
      3: case ($urandom_range(0, 4))
           0: c = 16'h7FFF;
           1: c = 16'h8000;
           2: c = 16'h0000;
           3: c = 16'h0001;
           default: c = 16'hFFFF;
         endcase
      default: c = 16'($signed($urandom_range(0, 64)) + 224);
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rand_input();
    return $urandom_range(0, 1) ? 16'($urandom) : 16'($signed($urandom_range(0, 2048)) - 1024);
  endfunction

  // Receiver: after each word it takes, it draws a stall of random length (none
  // when idle_on is clear), or a long one when asked, so the pipeline backs up into the input side.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = (hold_left != 0);
      if (hold_left != 0) hold_left--;
      @(posedge clk);
      if (out_valid && !out_stall && !rst) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word, status", status, 0);
        end else begin
          coord_word_t want;
          want = pending_words.pop_front();
          if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
          if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
          if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
          if (status !== want.st) report_mismatch("status", status, want.st);
        end
        if (long_hold) begin
          hold_left = 300;
          long_hold = 0;
        end else begin
          hold_left = idle_on ? $urandom_range(0, 7) : 0;
        end
      end
    end
  end

  // Directed plan. Identity basis first, where results are plain shifts,
  // then a large origin, a tiny basis that overflows the quotient, a
  // degenerate basis, and a return to a valid one.
  plan_line_t plan [] = '{
    '{0, 0, 0, OP_POINT_FROM, 0, 0, 0, 1, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_POINT_TO, 32767, 32767, 32767, 1, 8388352, 8388352, 8388352, ST_OK},
    '{0, 0, 0, OP_POINT_TO, -32768, -32768, -32768, 1,
      -8388608, -8388608, -8388608, ST_OK},
    '{0, 0, 0, OP_VECTOR_FROM, 1, -1, 256, 1, 256, -256, 65536, ST_OK},
    '{0, 0, 0, OP_VECTOR_TO, -1, 0, 1, 1, -256, 0, 256, ST_OK},
    '{0, 0, 0, OP_POINT_FROM, -32768, 32767, -1, 1, -8388608, 8388352, -256, ST_OK},
    '{1, REG_ORIGIN, 48'h0100_8000_7FFF, OP_POINT_FROM, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_POINT_FROM, -32768, 32767, 0, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_POINT_TO, 32767, -32768, 0, 0, 0, 0, 0, ST_OK},
    '{1, REG_BASIS_I, 48'h0000_0000_0001, OP_POINT_FROM, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{1, REG_BASIS_J, 48'h0000_0001_0000, OP_POINT_FROM, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{1, REG_BASIS_K, 48'h0001_0000_0000, OP_POINT_FROM, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_POINT_FROM, -32768, 0, 0, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_VECTOR_FROM, 32767, -32768, 1, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_VECTOR_TO, 32767, 32767, 32767, 0, 0, 0, 0, ST_OK},
    '{1, REG_BASIS_I, 48'hFFFF_FFFF_FFFF, OP_POINT_FROM, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_POINT_TO, -32768, -32768, -32768, 0, 0, 0, 0, ST_OK},
    '{1, REG_BASIS_K, 48'h0, OP_POINT_FROM, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_POINT_FROM, 5, 5, 5, 1, 0, 0, 0, ST_NOT_BASIS},
    '{0, 0, 0, OP_POINT_TO, -7, 32767, 5, 1, 0, 0, 0, ST_NOT_BASIS},
    '{0, 0, 0, OP_VECTOR_FROM, 5, -32768, 5, 1, 0, 0, 0, ST_NOT_BASIS},
    '{0, 0, 0, OP_VECTOR_TO, 1, 2, 3, 1, 0, 0, 0, ST_NOT_BASIS},
    '{1, REG_BASIS_K, 48'h7FFF_0001_8000, OP_POINT_FROM, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{0, 0, 0, OP_VECTOR_FROM, 300, -20000, 32767, 0, 0, 0, 0, ST_OK}
  };

  initial begin
    coord_word_t want;
    logic [REG_W-1:0] r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = OP_POINT_FROM;
    in_x      = '0;
    in_y      = '0;
    in_z      = '0;
    cfg_write = 1'b0;
    cfg_index = REG_BASIS_I;
    cfg_data  = '0;
    basis_regs[REG_BASIS_I] = BASIS_I_RESET;
    basis_regs[REG_BASIS_J] = BASIS_J_RESET;
    basis_regs[REG_BASIS_K] = BASIS_K_RESET;
    basis_regs[REG_ORIGIN]  = ORIGIN_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (plan[i].typed) begin
          want = '{x: plan[i].ex, y: plan[i].ey, z: plan[i].ez, st: plan[i].st};
        end else begin
          want = transform(plan[i].op, plan[i].px, plan[i].py, plan[i].pz);
        end
        send_word(plan[i].op, plan[i].px, plan[i].py, plan[i].pz, want);
      end
    end

    // Random phases, each under a fresh basis. One phase runs with no
    // idling at all, one has a long receiver stall after its first word, and one uses a
    // degenerate basis with two equal vectors.
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 4; k++) begin
        r = {rand_comp(), rand_comp(), rand_comp()};
        write_reg(k[1:0], r);
      end
      if (ph == 5) write_reg(REG_BASIS_K, basis_regs[REG_BASIS_I]);
      idle_on   = (ph != 3);
      long_hold = (ph == 2);
      for (int n = 0; n < 50; n++) begin
        cob_op_t op;
        logic signed [15:0] px, py, pz;
        op = cob_op_t'($urandom_range(0, 3));
        px = rand_input();
        py = rand_input();
        pz = rand_input();
        send_word(op, px, py, pz, transform(op, px, py, pz));
      end
    end
    in_valid = 1'b0;
    idle_on  = 1'b1;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("change_of_basis_3d test passed");
    end else begin
      $display("change_of_basis_3d test failed");
    end
    $finish;
  end

endmodule
